>>> rtl/mpbe_pkg.sv
// Shared types, command codes and column mapping for the mirrored playfield bitmap engine.
package mpbe_pkg;

   typedef logic [23:0] row_word_type;

   typedef enum logic [2:0] {
      OP_PIXEL      = 3'd0,
      OP_READ_PIXEL = 3'd1,
      OP_HLINE      = 3'd2,
      OP_VLINE      = 3'd3,
      OP_FILL       = 3'd4,
      OP_SCROLL     = 3'd5,
      OP_READ_ROW   = 3'd6,
      OP_NOP        = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      DIR_UP         = 2'd0,
      DIR_DOWN       = 2'd1,
      DIR_ROT_LEFT   = 2'd2,
      DIR_ROT_RIGHT  = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_LINE   = 2'd1,
      BK_ROTATE = 2'd2
   } bk_state_type;

   // Draw modes; the unused code behaves as toggle.
   localparam logic [1:0] MODE_SET    = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_TOGGLE = 2'd2;

   localparam int COL_LAST         = 31;
   localparam int COL_MIRROR_START = 20;
   localparam int COL_MIRROR_SUM   = 39;
   localparam int COL_BYTE_B_START = 4;
   localparam int COL_BYTE_C_START = 12;
   localparam int BIT_TOP          = 23;
   localparam int BYTE_B_SHIFT     = 4;
   localparam int QUEUE_DEPTH      = 2;

   typedef struct packed {
      opcode_type  op;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [1:0]  mode;
      logic [7:0]  fill;
      dir_type     dir;
   } cmd_type;

   // Bit position of a logical column (0-31) in a row word {a, b, c}.
   function automatic logic [4:0] pix_index(input logic [4:0] col);
      logic [5:0] m;
      logic [5:0] p;
      if (col >= 5'(COL_MIRROR_START)) begin
         m = 6'(COL_MIRROR_SUM) - {1'b0, col};
      end else begin
         m = {1'b0, col};
      end
      if (m < 6'(COL_BYTE_B_START)) begin
         p = 6'(BIT_TOP) - m;
      end else if (m < 6'(COL_BYTE_C_START)) begin
         p = m + 6'(BYTE_B_SHIFT);
      end else begin
         p = m - 6'(COL_BYTE_C_START);
      end
      return p[4:0];
   endfunction

   function automatic logic apply_mode(input logic old_bit, input logic [1:0] mode);
      logic r;
      case (mode)
         MODE_SET:   r = 1'b1;
         MODE_CLEAR: r = 1'b0;
         default:    r = ~old_bit;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/mpbe_front.sv
// Command front end: accept, sort line ends and queue commands for the back end.
module mpbe_front
   import mpbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_coord_x,
   input  logic [7:0]  req_coord_y,
   input  logic [7:0]  req_end_coord,
   input  logic [1:0]  req_draw_mode,
   input  logic [7:0]  req_fill_byte,
   input  logic [1:0]  req_scroll_dir,
   input  logic        pop,
   output logic        cmd_valid,
   output cmd_type     cmd
);

   cmd_type    entries_ff [QUEUE_DEPTH];
   cmd_type    entries_in [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   cmd_type    dec;
   logic [7:0] key;
   logic       push;

   // Classify: a line sorts its two ends here so the back end only counts up.
   always_comb begin
      dec.op   = opcode_type'(req_opcode);
      dec.x    = req_coord_x;
      dec.y    = req_coord_y;
      dec.mode = req_draw_mode;
      dec.fill = req_fill_byte;
      dec.dir  = dir_type'(req_scroll_dir);
      key      = (dec.op == OP_VLINE) ? req_coord_y : req_coord_x;
      if (key < req_end_coord) begin
         dec.lo = key;
         dec.hi = req_end_coord;
      end else begin
         dec.lo = req_end_coord;
         dec.hi = key;
      end
   end

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entries_ff[rd_ptr_ff];

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = dec;
         wr_ptr_in             = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/mpbe_back.sv
// Command back end: playfield rows, pixel read-modify-write, line and rotate sequencer.
module mpbe_back
   import mpbe_pkg::*;
#(
   parameter int ROW_COUNT = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pixel_bit,
   output logic [7:0]  rsp_row_byte_a,
   output logic [7:0]  rsp_row_byte_b,
   output logic [7:0]  rsp_row_byte_c
);

   localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

   bk_state_type     state_ff, state_in;
   row_word_type     rows_ff [ROW_COUNT];
   row_word_type     rows_in [ROW_COUNT];
   cmd_type          cur_ff, cur_in;
   logic [7:0]       idx_ff, idx_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [4:0]       step_ff, step_in;
   logic             edge_ff, edge_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             pixel_bit_ff, pixel_bit_in;
   logic [7:0]       byte_a_ff, byte_a_in;
   logic [7:0]       byte_b_ff, byte_b_in;
   logic [7:0]       byte_c_ff, byte_c_in;

   logic             out_free;
   logic             line_done;
   logic             rot_done;
   logic             rot_cmd;
   logic             rot_left;
   logic [4:0]       rot_dst;
   logic [4:0]       rot_src;
   logic [4:0]       rot_edge_col;
   logic             rot_bit;
   logic [7:0]       px_col;
   logic [7:0]       px_y;
   logic [1:0]       px_mode;
   logic [4:0]       px_row;
   logic             px_ok;
   logic             rd_ok;
   logic [ROW_W-1:0] rd_idx;
   row_word_type     rd_word;
   row_word_type     new_word;
   logic [4:0]       pos;
   logic             old_bit;
   logic             wr_en;
   logic             rsp_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == BK_IDLE) && cmd_valid && out_free;
   assign line_done = (state_ff == BK_LINE) && (idx_ff == cur_ff.hi);
   assign rot_done  = (state_ff == BK_ROTATE) && (step_ff == 5'(COL_LAST)) &&
                      (row_ff == ROW_LAST);
   assign rot_cmd   = (cmd.dir == DIR_ROT_LEFT) || (cmd.dir == DIR_ROT_RIGHT);

   // Rotate walk: destination and source columns of the current step.
   assign rot_left     = (cur_ff.dir == DIR_ROT_LEFT);
   assign rot_dst      = rot_left ? step_ff : ~step_ff;
   assign rot_src      = rot_left ? (step_ff + 5'd1) : (5'(COL_LAST - 1) - step_ff);
   assign rot_edge_col = rot_left ? 5'd0 : 5'(COL_LAST);

   // Pixel address for this cycle.
   always_comb begin
      case (state_ff)
         BK_LINE: begin
            if (cur_ff.op == OP_HLINE) begin
               px_col = idx_ff;
               px_y   = cur_ff.y;
            end else begin
               px_col = cur_ff.x;
               px_y   = idx_ff;
            end
         end
         BK_ROTATE: begin
            px_col = {3'b000, rot_dst};
            px_y   = 8'({row_ff, 3'b000});
         end
         default: begin
            px_col = cmd.x;
            px_y   = cmd.y;
         end
      endcase
   end

   assign px_row = px_y[7:3];
   assign px_ok  = (px_col[7:5] == 3'd0) && ({1'b0, px_row} < 6'(ROW_COUNT));

   // Single row read port, shared by pixel access and row readout.
   always_comb begin
      if ((state_ff == BK_IDLE) && (cmd.op == OP_READ_ROW)) begin
         rd_ok  = (cmd.y < 8'(ROW_COUNT));
         rd_idx = cmd.y[ROW_W-1:0];
      end else begin
         rd_ok  = px_ok;
         rd_idx = px_row[ROW_W-1:0];
      end
      rd_word = rd_ok ? rows_ff[rd_idx] : '0;
   end

   assign rot_bit = (step_ff == 5'(COL_LAST)) ? edge_ff : rd_word[pix_index(rot_src)];

   always_comb begin
      case (state_ff)
         BK_LINE:   px_mode = cur_ff.mode;
         BK_ROTATE: px_mode = rot_bit ? MODE_SET : MODE_CLEAR;
         default:   px_mode = cmd.mode;
      endcase
      pos           = pix_index(px_col[4:0]);
      old_bit       = rd_word[pos];
      new_word      = rd_word;
      new_word[pos] = apply_mode(old_bit, px_mode);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop && ((cmd.op == OP_HLINE) || (cmd.op == OP_VLINE))) begin
               state_in = BK_LINE;
            end else if (pop && (cmd.op == OP_SCROLL) && rot_cmd) begin
               state_in = BK_ROTATE;
            end
         end
         BK_LINE: begin
            if (line_done) begin
               state_in = BK_IDLE;
            end
         end
         BK_ROTATE: begin
            if (rot_done) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      rows_in      = rows_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      edge_in      = edge_ff;
      pixel_bit_in = pixel_bit_ff;
      byte_a_in    = byte_a_ff;
      byte_b_in    = byte_b_ff;
      byte_c_in    = byte_c_ff;
      wr_en        = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         BK_LINE: begin
            wr_en  = px_ok;
            idx_in = idx_ff + 8'd1;
            if (line_done) begin
               rsp_load     = 1'b1;
               pixel_bit_in = 1'b0;
               byte_a_in    = '0;
               byte_b_in    = '0;
               byte_c_in    = '0;
            end
         end
         BK_ROTATE: begin
            wr_en   = 1'b1;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd0) begin
               edge_in = rd_word[pix_index(rot_edge_col)];
            end
            if (step_ff == 5'(COL_LAST)) begin
               row_in = row_ff + ROW_W'(1);
            end
            if (rot_done) begin
               rsp_load     = 1'b1;
               pixel_bit_in = 1'b0;
               byte_a_in    = '0;
               byte_b_in    = '0;
               byte_c_in    = '0;
            end
         end
         default: begin
            if (pop) begin
               cur_in  = cmd;
               idx_in  = cmd.lo;
               row_in  = '0;
               step_in = '0;
               case (cmd.op)
                  OP_PIXEL: begin
                     wr_en = px_ok;
                  end
                  OP_FILL: begin
                     for (int r = 0; r < ROW_COUNT; r++) begin
                        rows_in[r] = {cmd.fill, cmd.fill, cmd.fill};
                     end
                  end
                  OP_SCROLL: begin
                     case (cmd.dir)
                        DIR_UP: begin
                           for (int r = 0; r < ROW_COUNT; r++) begin
                              if (r < ROW_COUNT - 1) begin
                                 rows_in[r] = rows_ff[r + 1];
                              end else begin
                                 rows_in[r] = '0;
                              end
                           end
                        end
                        DIR_DOWN: begin
                           for (int r = 0; r < ROW_COUNT; r++) begin
                              if (r > 0) begin
                                 rows_in[r] = rows_ff[r - 1];
                              end else begin
                                 rows_in[r] = '0;
                              end
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
               // Everything except lines and rotations answers at once.
               if (!((cmd.op == OP_HLINE) || (cmd.op == OP_VLINE) ||
                     ((cmd.op == OP_SCROLL) && rot_cmd))) begin
                  rsp_load     = 1'b1;
                  pixel_bit_in = (cmd.op == OP_READ_PIXEL) && px_ok && old_bit;
                  if (cmd.op == OP_READ_ROW) begin
                     byte_a_in = rd_word[23:16];
                     byte_b_in = rd_word[15:8];
                     byte_c_in = rd_word[7:0];
                  end else begin
                     byte_a_in = '0;
                     byte_b_in = '0;
                     byte_c_in = '0;
                  end
               end
            end
         end
      endcase

      if (wr_en) begin
         rows_in[rd_idx] = new_word;
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      edge_ff      <= edge_in;
      pixel_bit_ff <= pixel_bit_in;
      byte_a_ff    <= byte_a_in;
      byte_b_ff    <= byte_b_in;
      byte_c_ff    <= byte_c_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         for (int r = 0; r < ROW_COUNT; r++) begin
            rows_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         rows_ff      <= rows_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_bit  = pixel_bit_ff;
   assign rsp_row_byte_a = byte_a_ff;
   assign rsp_row_byte_b = byte_b_ff;
   assign rsp_row_byte_c = byte_c_ff;

endmodule

>>> rtl/mirrored_playfield_bitmap_engine_unit.sv
// Pixel, read, fill and scroll commands pass through the queue and then the output register.
// Throughput: one such command per cycle while neither the queue nor the result stalls; a
// line or a rotate holds the back end for its whole walk, the pace being
// set by the single pixel read-modify-write path that walks one column per cycle.
// Reset: synchronous, active high; clears every playfield row, the queue and the result valid flag.
module mirrored_playfield_bitmap_engine_unit
   import mpbe_pkg::*;
#(
   parameter int ROW_COUNT = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_coord_x,
   input  logic [7:0]  req_coord_y,
   input  logic [7:0]  req_end_coord,
   input  logic [1:0]  req_draw_mode,
   input  logic [7:0]  req_fill_byte,
   input  logic [1:0]  req_scroll_dir,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pixel_bit,
   output logic [7:0]  rsp_row_byte_a,
   output logic [7:0]  rsp_row_byte_b,
   output logic [7:0]  rsp_row_byte_c
);

   // Queue head handed from front end to back end.
   cmd_type cmd;
   logic    cmd_valid;
   logic    pop;

   // Front end: take each request transaction, sort line ends, and hold it in a
   // two-entry queue so request acceptance carries on while the back end is busy.
   mpbe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_end_coord  (req_end_coord),
      .req_draw_mode  (req_draw_mode),
      .req_fill_byte  (req_fill_byte),
      .req_scroll_dir (req_scroll_dir),
      .pop            (pop),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd)
   );

   // Back end: own the playfield, execute one command at a time and drop its
   // single result into the output register, which parts it from the response side.
   // Lines advance one coordinate per cycle so aliased toggles repeat; rotations copy
   // pixel by pixel after capturing the edge bit of each row.
   mpbe_back #(
      .ROW_COUNT (ROW_COUNT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_bit  (rsp_pixel_bit),
      .rsp_row_byte_a (rsp_row_byte_a),
      .rsp_row_byte_b (rsp_row_byte_b),
      .rsp_row_byte_c (rsp_row_byte_c)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the mirrored playfield bitmap engine unit.
`timescale 1ns / 100ps

module tb_top;
   import mpbe_pkg::*;

   localparam int PLAYFIELD_ROWS  = 11;
   localparam int SCANLINE_LAST   = PLAYFIELD_ROWS * 8 - 1;
   localparam int PAUSE_MAX       = 13;
   localparam int RANDOM_ITEMS    = 1600;
   // Long receiver hold-off: applied once, after this many results.
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 400;
   // Worst legal quiet stretch is the hold-off plus a full rotate; allow far more.
   localparam int IDLE_LIMIT      = 5000;
   localparam int DRAIN_CYCLES    = 40;
   // Undefined draw mode code; the block treats it as toggle.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      opcode_type  op;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  e;
      logic [1:0]  mode;
      logic [7:0]  fill;
      dir_type     dir;
   } playfield_cmd_t;

   typedef struct {
      logic        pixel;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
   } row_readout_t;

   // Shadow copy of the playfield: applies each accepted command and
   // keeps the readouts that the block owes, oldest first.
   class playfield_mirror;
      logic [7:0]   row_bytes [PLAYFIELD_ROWS][3];
      row_readout_t expected_readouts[$];
      int           mismatch_count;

      function new();
         mismatch_count = 0;
         foreach (row_bytes[r, k]) row_bytes[r][k] = 8'h00;
      endfunction

      // Resolve column and scanline to row, byte lane and bit mask; 0 when off the field.
      function bit locate(input int col, input int line, output int row, output int lane,
                          output logic [7:0] mask);
         int c;
         c    = col;
         row  = line >> 3;
         lane = 0;
         mask = 8'h00;
         if (c > COL_LAST || row >= PLAYFIELD_ROWS) return 1'b0;
         if (c >= COL_MIRROR_START) c = COL_MIRROR_SUM - c;
         if (c < COL_BYTE_B_START) begin
            lane = 0;
            mask = 8'h80 >> c;
         end else if (c < COL_BYTE_C_START) begin
            lane = 1;
            mask = 8'h01 << (c - COL_BYTE_B_START);
         end else begin
            lane = 2;
            mask = 8'h01 << (c - COL_BYTE_C_START);
         end
         return 1'b1;
      endfunction

      function void plot(input int col, input int line, input logic [1:0] mode);
         int row, lane;
         logic [7:0] mask;
         if (!locate(col, line, row, lane, mask)) return;
         case (mode)
            MODE_SET: begin
               row_bytes[row][lane] |= mask;
            end
            MODE_CLEAR: begin
               row_bytes[row][lane] &= ~mask;
            end
            default: begin
               row_bytes[row][lane] ^= mask;
            end
         endcase
      endfunction

      function logic peek(input int col, input int line);
         int row, lane;
         logic [7:0] mask;
         if (!locate(col, line, row, lane, mask)) return 1'b0;
         return (row_bytes[row][lane] & mask) != 8'h00;
      endfunction

      // Rotation walks the columns one at a time, so aliased columns see earlier copies.
      function void rotate_rows(input dir_type dir);
         int line, c;
         logic edge_bit;
         for (int r = 0; r < PLAYFIELD_ROWS; r++) begin
            line = r << 3;
            if (dir == DIR_ROT_LEFT) begin
               edge_bit = peek(0, line);
               for (c = 0; c < COL_LAST; c++)
                  plot(c, line, peek(c + 1, line) ? MODE_SET : MODE_CLEAR);
               plot(COL_LAST, line, edge_bit ? MODE_SET : MODE_CLEAR);
            end else begin
               edge_bit = peek(COL_LAST, line);
               for (c = COL_LAST; c > 0; c--)
                  plot(c, line, peek(c - 1, line) ? MODE_SET : MODE_CLEAR);
               plot(0, line, edge_bit ? MODE_SET : MODE_CLEAR);
            end
         end
      endfunction

      function void note_command(input playfield_cmd_t cmd);
         row_readout_t owed;
         int lo, hi, i, r, k;
         owed = '{pixel: 1'b0, a: 8'h00, b: 8'h00, c: 8'h00};
         case (cmd.op)
            OP_PIXEL: begin
               plot(cmd.x, cmd.y, cmd.mode);
            end
            OP_READ_PIXEL: begin
               owed.pixel = peek(cmd.x, cmd.y);
            end
            OP_HLINE: begin
               lo = (cmd.x < cmd.e) ? cmd.x : cmd.e;
               hi = (cmd.x < cmd.e) ? cmd.e : cmd.x;
               for (i = lo; i <= hi; i++) plot(i, cmd.y, cmd.mode);
            end
            OP_VLINE: begin
               lo = (cmd.y < cmd.e) ? cmd.y : cmd.e;
               hi = (cmd.y < cmd.e) ? cmd.e : cmd.y;
               for (i = lo; i <= hi; i++) plot(cmd.x, i, cmd.mode);
            end
            OP_FILL: begin
               foreach (row_bytes[r2, k2]) row_bytes[r2][k2] = cmd.fill;
            end
            OP_SCROLL: begin
               case (cmd.dir)
                  DIR_UP: begin
                     for (r = 0; r < PLAYFIELD_ROWS - 1; r++)
                        for (k = 0; k < 3; k++) row_bytes[r][k] = row_bytes[r + 1][k];
                     for (k = 0; k < 3; k++) row_bytes[PLAYFIELD_ROWS - 1][k] = 8'h00;
                  end
                  DIR_DOWN: begin
                     for (r = PLAYFIELD_ROWS - 1; r > 0; r--)
                        for (k = 0; k < 3; k++) row_bytes[r][k] = row_bytes[r - 1][k];
                     for (k = 0; k < 3; k++) row_bytes[0][k] = 8'h00;
                  end
                  default: begin
                     rotate_rows(cmd.dir);
                  end
               endcase
            end
            OP_READ_ROW: begin
               if (cmd.y < PLAYFIELD_ROWS) begin
                  owed.a = row_bytes[cmd.y][0];
                  owed.b = row_bytes[cmd.y][1];
                  owed.c = row_bytes[cmd.y][2];
               end
            end
            default: begin
            end
         endcase
         expected_readouts.push_back(owed);
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %02h, got %02h", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_readout(input row_readout_t got);
         row_readout_t want;
         if (expected_readouts.size() == 0) begin
            $error("unexpected result: pixel_bit %0b bytes %02h %02h %02h",
                   got.pixel, got.a, got.b, got.c);
            mismatch_count++;
            return;
         end
         want = expected_readouts.pop_front();
         compare_field("pixel_bit", {7'd0, want.pixel}, {7'd0, got.pixel});
         compare_field("row_byte_a", want.a, got.a);
         compare_field("row_byte_b", want.b, got.b);
         compare_field("row_byte_c", want.c, got.c);
      endfunction
   endclass

   // Clock, reset and the block's inputs: all known from time zero.
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode     = 3'd0;
   logic [7:0]  req_coord_x    = 8'd0;
   logic [7:0]  req_coord_y    = 8'd0;
   logic [7:0]  req_end_coord  = 8'd0;
   logic [1:0]  req_draw_mode  = 2'd0;
   logic [7:0]  req_fill_byte  = 8'd0;
   logic [1:0]  req_scroll_dir = 2'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic        rsp_pixel_bit;
   logic [7:0]  rsp_row_byte_a;
   logic [7:0]  rsp_row_byte_b;
   logic [7:0]  rsp_row_byte_c;

   playfield_mirror shadow = new();
   int sent_count  = 0;
   int taken_count = 0;

   always #1 clock = ~clock;

   mirrored_playfield_bitmap_engine_unit #(
      .ROW_COUNT(PLAYFIELD_ROWS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_end_coord  (req_end_coord),
      .req_draw_mode  (req_draw_mode),
      .req_fill_byte  (req_fill_byte),
      .req_scroll_dir (req_scroll_dir),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_bit  (rsp_pixel_bit),
      .rsp_row_byte_a (rsp_row_byte_a),
      .rsp_row_byte_b (rsp_row_byte_b),
      .rsp_row_byte_c (rsp_row_byte_c)
   );

   // Pause length for one transaction; every third run of 150 goes flat out.
   function automatic int draw_pause(input int seq);
      if ((seq / 150) % 3 == 2) return 0;
      return $urandom_range(0, PAUSE_MAX);
   endfunction

   // Random endpoint near a base coordinate, clamped to the 8-bit range 0-255.
   function automatic logic [7:0] near(input logic [7:0] base, input int reach);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Mostly pixel work on the visible field, with some lines, fills,
   // scrolls and rotates; a share of coordinates lands off the field.
   function automatic playfield_cmd_t random_command();
      playfield_cmd_t cmd;
      int pick;
      pick     = $urandom_range(0, 99);
      cmd.x    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, COL_LAST))
                                               : 8'($urandom_range(0, 255));
      cmd.y    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, SCANLINE_LAST))
                                               : 8'($urandom_range(0, 255));
      cmd.e    = 8'($urandom_range(0, 255));
      cmd.mode = 2'($urandom_range(0, 3));
      cmd.fill = 8'($urandom_range(0, 255));
      cmd.dir  = dir_type'($urandom_range(0, 3));
      if (pick < 35) begin
         cmd.op = OP_PIXEL;
      end else if (pick < 60) begin
         cmd.op = OP_READ_PIXEL;
      end else if (pick < 70) begin
         cmd.op = OP_HLINE;
         if ($urandom_range(0, 19) != 0) cmd.e = near(cmd.x, 10);
      end else if (pick < 78) begin
         cmd.op = OP_VLINE;
         if ($urandom_range(0, 19) != 0) cmd.e = near(cmd.y, 12);
      end else if (pick < 81) begin
         cmd.op = OP_FILL;
      end else if (pick < 87) begin
         cmd.op = OP_SCROLL;
      end else if (pick < 97) begin
         cmd.op = OP_READ_ROW;
         if ($urandom_range(0, 4) != 0) cmd.y = 8'($urandom_range(0, PLAYFIELD_ROWS + 1));
      end else begin
         cmd.op = OP_NOP;
      end
      return cmd;
   endfunction

   // Offer one transaction after a random gap and hold it until accepted.
   task automatic push_command(input playfield_cmd_t cmd);
      int gap;
      gap = draw_pause(sent_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= cmd.op;
      req_coord_x    <= cmd.x;
      req_coord_y    <= cmd.y;
      req_end_coord  <= cmd.e;
      req_draw_mode  <= cmd.mode;
      req_fill_byte  <= cmd.fill;
      req_scroll_dir <= cmd.dir;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.note_command(cmd);
      sent_count++;
   endtask

   task automatic issue(input opcode_type op, input int x, input int y, input int e,
                        input logic [1:0] mode, input int fill, input dir_type dir);
      playfield_cmd_t cmd;
      cmd = '{op: op, x: 8'(x), y: 8'(y), e: 8'(e), mode: mode, fill: 8'(fill), dir: dir};
      push_command(cmd);
   endtask

   // Stimulus: directed corners first, then the random stream, then drain.
   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Set and read back the first column, then a mirrored column and its alias.
      issue(OP_PIXEL,      0,  0, 0, MODE_SET, 0, DIR_UP);
      issue(OP_READ_PIXEL, 0,  0, 0, MODE_SET, 0, DIR_UP);
      issue(OP_PIXEL,      31, 0, 0, MODE_SET, 0, DIR_UP);
      issue(OP_READ_PIXEL, 8,  0, 0, MODE_SET, 0, DIR_UP);
      // Spare draw mode behaves as toggle, on the last scanline of the field.
      issue(OP_PIXEL,      19, SCANLINE_LAST, 0, MODE_SPARE, 0, DIR_UP);
      issue(OP_READ_PIXEL, 20, SCANLINE_LAST, 0, MODE_SET, 0, DIR_UP);
      // Off the right edge and below the last row: writes dropped, reads zero.
      issue(OP_PIXEL,      32, 0, 0, MODE_SET, 0, DIR_UP);
      issue(OP_PIXEL,      0, SCANLINE_LAST + 1, 0, MODE_SET, 0, DIR_UP);
      issue(OP_READ_PIXEL, 255, 255, 255, MODE_SPARE, 255, DIR_ROT_RIGHT);
      // Reversed line ends; the toggle hits aliased columns twice.
      issue(OP_HLINE, 31, 16, 0, MODE_TOGGLE, 0, DIR_UP);
      issue(OP_HLINE, 0, 255, 255, MODE_SET, 0, DIR_UP);
      issue(OP_VLINE, 12, SCANLINE_LAST, 0, MODE_SET, 0, DIR_UP);
      issue(OP_VLINE, 3, 0, 255, MODE_CLEAR, 0, DIR_UP);
      issue(OP_READ_ROW, 0, 0, 0, MODE_SET, 0, DIR_UP);
      issue(OP_READ_ROW, 0, PLAYFIELD_ROWS - 1, 0, MODE_SET, 0, DIR_UP);
      // Every scroll direction, with row readouts in between.
      issue(OP_SCROLL, 0, 0, 0, MODE_SET, 0, DIR_ROT_LEFT);
      issue(OP_SCROLL, 0, 0, 0, MODE_SET, 0, DIR_ROT_RIGHT);
      issue(OP_READ_ROW, 0, 2, 0, MODE_SET, 0, DIR_UP);
      issue(OP_SCROLL, 0, 0, 0, MODE_SET, 0, DIR_UP);
      issue(OP_SCROLL, 0, 0, 0, MODE_SET, 0, DIR_DOWN);
      issue(OP_READ_ROW, 0, PLAYFIELD_ROWS - 1, 0, MODE_SET, 0, DIR_UP);
      // Full fill, then row indexes past the end of the field.
      issue(OP_FILL, 0, 0, 0, MODE_SET, 255, DIR_UP);
      issue(OP_READ_ROW, 0, PLAYFIELD_ROWS, 0, MODE_SET, 0, DIR_UP);
      issue(OP_READ_ROW, 255, 255, 255, MODE_SPARE, 255, DIR_ROT_RIGHT);
      issue(OP_NOP, 255, 255, 255, MODE_SPARE, 255, DIR_ROT_RIGHT);

      for (int n = 0; n < RANDOM_ITEMS; n++) push_command(random_command());
      req_valid <= 1'b0;

      // Drain: wait for every owed result, then a margin for strays.
      while (shadow.expected_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatch_count == 0 && shadow.expected_readouts.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stall before each transaction, one long hold-off so
   // that the block backs up and stalls its input while the sender keeps offering.
   initial begin : result_sink
      int hold;
      bit held_off;
      row_readout_t got;
      held_off = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!held_off && taken_count == HOLD_OFF_AT) begin
            hold     = HOLD_OFF_CYCLES;
            held_off = 1'b1;
         end else begin
            hold = draw_pause(taken_count);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.pixel = rsp_pixel_bit;
         got.a     = rsp_row_byte_a;
         got.b     = rsp_row_byte_b;
         got.c     = rsp_row_byte_c;
         shadow.check_readout(got);
         taken_count++;
      end
   end

   // Watchdog: end the run when no transaction moves on either side for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule
